// File: design/ehtv_pkg.sv
// Package for the host text validator: tracker types, character codes,
// limits and per-byte update functions. No dependencies.
`default_nettype none

package ehtv_pkg;

	// Character codes
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_HYPHEN = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Limits
	localparam logic [7:0] COUNT_MAX     = 8'd255;
	localparam logic [7:0] NAME_MAX_LEN  = 8'd253;
	localparam logic [6:0] LABEL_MAX_LEN = 7'd63;
	localparam logic [6:0] LABEL_SAT     = 7'd64;
	localparam logic [7:0] V6_MIN_LEN    = 8'd2;
	localparam logic [7:0] V6_MAX_LEN    = 8'd45;
	localparam logic [3:0] V6_GROUPS     = 4'd8;
	localparam logic [3:0] V6_SEG_SAT    = 4'd15;
	localparam logic [3:0] V6_HEX_MAX    = 4'd4;
	localparam logic [4:0] V4_LEN_SAT    = 5'd31;
	localparam logic [4:0] V4_MIN_LEN    = 5'd7;
	localparam logic [4:0] V4_MAX_LEN    = 5'd15;
	localparam logic [2:0] V4_PARTS      = 3'd4;
	localparam logic [2:0] V4_GROUP_SAT  = 3'd7;
	localparam logic [2:0] V4_DIGIT_MAX  = 3'd3;
	localparam logic [2:0] V4_PART_SAT   = 3'd4;
	localparam logic [9:0] V4_PART_MAX   = 10'd255;

	typedef struct packed {
		logic [4:0] len;
		logic [2:0] part_len;
		logic [9:0] part_val;
		logic       lead_zero;
		logic [2:0] groups;
		logic       ok;
	} v4_trk_t;

	typedef struct packed {
		logic       compressed;
		logic [3:0] groups;
		logic [3:0] seg_len;
		logic       seg_dot;
		logic       seg_hex;
		logic       ok;
	} v6_trk_t;

	typedef struct packed {
		logic [6:0] len;
		logic       dot;
		logic       non_digit;
		logic       ok;
	} lbl_trk_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
			((c >= 8'h41) && (c <= 8'h46));
	endfunction

	function automatic v4_trk_t v4_reset_val();
		v4_trk_t t;
		t = '0;
		t.ok = 1'b1;
		return t;
	endfunction

	// Close the current decimal part and check it
	function automatic v4_trk_t v4_close(input v4_trk_t t);
		v4_trk_t r;
		r = t;
		if ((t.part_len == 3'd0) || (t.part_len > V4_DIGIT_MAX) ||
			((t.part_len > 3'd1) && t.lead_zero) || (t.part_val > V4_PART_MAX)) begin
			r.ok = 1'b0;
		end
		if (t.groups != V4_GROUP_SAT) begin
			r.groups = t.groups + 3'd1;
		end
		r.part_len = 3'd0;
		r.part_val = 10'd0;
		r.lead_zero = 1'b0;
		return r;
	endfunction

	function automatic v4_trk_t v4_feed(input v4_trk_t t, input logic [7:0] c);
		v4_trk_t r;
		logic [9:0] d;
		r = t;
		d = {6'd0, c[3:0]};
		if (r.len != V4_LEN_SAT) begin
			r.len = r.len + 5'd1;
		end
		if (c == CH_DOT) begin
			r = v4_close(r);
		end else begin
			if (t.part_len == 3'd0) begin
				r.lead_zero = (c == CH_ZERO);
			end
			if (t.part_len != V4_PART_SAT) begin
				r.part_len = t.part_len + 3'd1;
			end
			if (is_digit(c)) begin
				if (r.part_len <= V4_DIGIT_MAX) begin
					// val * 10 + digit; val stays below 100 here
					r.part_val = {t.part_val[6:0], 3'b000} + {t.part_val[8:0], 1'b0} + d;
				end
			end else begin
				r.ok = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic logic v4_done(input v4_trk_t t);
		v4_trk_t r;
		r = v4_close(t);
		return r.ok && (r.groups == V4_PARTS) && (r.len >= V4_MIN_LEN) &&
			(r.len <= V4_MAX_LEN);
	endfunction

	function automatic logic [3:0] v6_add(input logic [3:0] g, input logic [3:0] n);
		logic [4:0] s;
		s = {1'b0, g} + {1'b0, n};
		return s[4] ? V6_SEG_SAT : s[3:0];
	endfunction

endpackage

`default_nettype wire

// File: design/endpoint_host_text_validator.sv
// Host text validator top level: input stage, per-byte trackers, result register.
// Depends on ehtv_pkg.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------
//  input    | in_valid/in_ready  | ch[7:0], last
//  result   | out_valid/out_ready| ipv4_ok, ipv6_ok, name_ok, host_ok
//
// One byte per cycle while in_ready is high. An accepted byte is registered in
// the input stage; there the trackers update from it, and on a last byte the
// verdicts are loaded into the result register, which raises out_valid and
// holds the result until out_ready takes it. Reset clears the stage, trackers
// and result valid.
// A stalled result only blocks a last byte in the input stage; other bytes
// keep flowing, so in_ready drops only when a second string ends while the
// previous result is still waiting.
`default_nettype none

module endpoint_host_text_validator (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] ch,
	input  wire logic       last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            ipv4_ok,
	output logic            ipv6_ok,
	output logic            name_ok,
	output logic            host_ok
);
	import ehtv_pkg::*;

	// Input stage
	logic       v_s1;
	logic [7:0] ch_s1;
	logic       last_s1;
	logic       adv_s1;

	// String state
	logic [7:0] byte_count_q;
	logic [7:0] prev_byte_q;
	logic [7:0] prev_prev_byte_q;
	v4_trk_t    v4_q;
	v6_trk_t    v6_q;
	v4_trk_t    emb_q;
	lbl_trk_t   lbl_q;

	// Result register
	logic out_valid_q;
	logic ipv4_q, ipv6_q, name_q;

	// Next state and verdicts
	logic [7:0] bc_nxt;
	v4_trk_t    v4_nxt;
	v6_trk_t    v6_nxt;
	v4_trk_t    emb_nxt;
	lbl_trk_t   lbl_nxt;
	v6_trk_t    v6_fin;
	logic       v4_res, v6_res, name_res;
	logic       is_colon;

	// A last byte needs a free result register; other bytes always advance
	assign adv_s1   = v_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	always_comb begin
		is_colon = (ch_s1 == CH_COLON);
		bc_nxt = (byte_count_q == COUNT_MAX) ? byte_count_q : byte_count_q + 8'd1;

		// dotted IPv4 over the whole string
		v4_nxt = v4_feed(v4_q, ch_s1);
		v4_res = v4_done(v4_nxt);

		// IPv6 groups and segments
		v6_nxt  = v6_q;
		emb_nxt = emb_q;
		if ((bc_nxt == V6_MIN_LEN) && (prev_byte_q == CH_COLON) && !is_colon) begin
			v6_nxt.ok = 1'b0;
		end
		if (is_colon) begin
			if (prev_byte_q == CH_COLON) begin
				if ((prev_prev_byte_q == CH_COLON) || v6_q.compressed) begin
					v6_nxt.ok = 1'b0;
				end
				v6_nxt.compressed = 1'b1;
			end
			if (v6_q.seg_len != 4'd0) begin
				if (v6_q.seg_dot || (v6_q.seg_len > V6_HEX_MAX) || !v6_q.seg_hex) begin
					v6_nxt.ok = 1'b0;
				end else begin
					v6_nxt.groups = v6_add(v6_q.groups, 4'd1);
				end
			end
			v6_nxt.seg_len = 4'd0;
			v6_nxt.seg_dot = 1'b0;
			v6_nxt.seg_hex = 1'b1;
			emb_nxt = v4_reset_val();
		end else begin
			if (v6_q.seg_len != V6_SEG_SAT) begin
				v6_nxt.seg_len = v6_q.seg_len + 4'd1;
			end
			if (ch_s1 == CH_DOT) begin
				v6_nxt.seg_dot = 1'b1;
			end
			if (!is_hex(ch_s1)) begin
				v6_nxt.seg_hex = 1'b0;
			end
			emb_nxt = v4_feed(emb_q, ch_s1);
		end

		// close the trailing segment on a last byte
		v6_fin = v6_nxt;
		if (is_colon && (prev_byte_q != CH_COLON)) begin
			v6_fin.ok = 1'b0;
		end
		if (v6_nxt.seg_len != 4'd0) begin
			if (v6_nxt.seg_dot) begin
				if (v4_done(emb_nxt)) begin
					v6_fin.groups = v6_add(v6_nxt.groups, 4'd2);
				end else begin
					v6_fin.ok = 1'b0;
				end
			end else if ((v6_nxt.seg_len > V6_HEX_MAX) || !v6_nxt.seg_hex) begin
				v6_fin.ok = 1'b0;
			end else begin
				v6_fin.groups = v6_add(v6_nxt.groups, 4'd1);
			end
		end
		v6_res = v6_fin.ok && (bc_nxt >= V6_MIN_LEN) && (bc_nxt <= V6_MAX_LEN) &&
			(v6_fin.compressed ? (v6_fin.groups < V6_GROUPS) : (v6_fin.groups == V6_GROUPS));

		// domain name labels
		lbl_nxt = lbl_q;
		if (ch_s1 == CH_DOT) begin
			if ((lbl_q.len == 7'd0) || (lbl_q.len > LABEL_MAX_LEN) ||
				(prev_byte_q == CH_HYPHEN)) begin
				lbl_nxt.ok = 1'b0;
			end
			lbl_nxt.len = 7'd0;
			lbl_nxt.dot = 1'b1;
		end else begin
			if (!(is_alpha(ch_s1) || is_digit(ch_s1) || (ch_s1 == CH_HYPHEN))) begin
				lbl_nxt.ok = 1'b0;
			end
			if (is_alpha(ch_s1) || (ch_s1 == CH_HYPHEN)) begin
				lbl_nxt.non_digit = 1'b1;
			end
			if ((lbl_q.len == 7'd0) && (ch_s1 == CH_HYPHEN)) begin
				lbl_nxt.ok = 1'b0;
			end
			if (lbl_q.len != LABEL_SAT) begin
				lbl_nxt.len = lbl_q.len + 7'd1;
			end
		end
		name_res = lbl_nxt.ok && lbl_nxt.dot && lbl_nxt.non_digit && (lbl_nxt.len != 7'd0) &&
			(lbl_nxt.len <= LABEL_MAX_LEN) && (ch_s1 != CH_HYPHEN) &&
			(bc_nxt <= NAME_MAX_LEN);
	end

	// Advance the trackers; drop back to the reset state after a last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q     <= 8'd0;
			prev_byte_q      <= 8'd0;
			prev_prev_byte_q <= 8'd0;
			v4_q             <= v4_reset_val();
			v6_q             <= '{compressed: 1'b0, groups: 4'd0, seg_len: 4'd0,
				seg_dot: 1'b0, seg_hex: 1'b1, ok: 1'b1};
			emb_q            <= v4_reset_val();
			lbl_q            <= '{len: 7'd0, dot: 1'b0, non_digit: 1'b0, ok: 1'b1};
		end else if (adv_s1) begin
			if (last_s1) begin
				byte_count_q     <= 8'd0;
				prev_byte_q      <= 8'd0;
				prev_prev_byte_q <= 8'd0;
				v4_q             <= v4_reset_val();
				v6_q             <= '{compressed: 1'b0, groups: 4'd0, seg_len: 4'd0,
					seg_dot: 1'b0, seg_hex: 1'b1, ok: 1'b1};
				emb_q            <= v4_reset_val();
				lbl_q            <= '{len: 7'd0, dot: 1'b0, non_digit: 1'b0, ok: 1'b1};
			end else begin
				byte_count_q     <= bc_nxt;
				prev_byte_q      <= ch_s1;
				prev_prev_byte_q <= prev_byte_q;
				v4_q             <= v4_nxt;
				v6_q             <= v6_nxt;
				emb_q            <= emb_nxt;
				lbl_q            <= lbl_nxt;
			end
		end
	end

	// Result register: load on a last byte, hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			ipv4_q <= v4_res;
			ipv6_q <= v6_res;
			name_q <= name_res;
		end
	end

	assign out_valid = out_valid_q;
	assign ipv4_ok   = ipv4_q;
	assign ipv6_ok   = ipv6_q;
	assign name_ok   = name_q;
	assign host_ok   = ipv4_q | ipv6_q | name_q;

	// A dotted quad has no colon and no letter, so it excludes the other two
	a_v4_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ipv4_ok |-> !ipv6_ok && !name_ok)
		else $error("ipv4 verdict overlaps another verdict");

	// Only a finished string waiting on a full result register may stall input
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && last_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a pending result");

	// Trackers restart after the last byte of a string
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> byte_count_q == 8'd0 && prev_byte_q == 8'd0 && lbl_q.ok)
		else $error("tracker state not cleared after last byte");

	// Every finished string produces a result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> out_valid_q)
		else $error("missing result after last byte");

endmodule

`default_nettype wire
